// ===== src/sbsm_pkg.sv =====
package sbsm_pkg;

   localparam int ADDR_W = 16;
   localparam int DATA_W = 8;
   localparam int BANK_W = 5;
   localparam int COUNT_W = 3;

   // address bits that pick the target register
   localparam int SEL_LSB = 13;
   localparam int SEL_MSB = 14;

   // data bits with a meaning of their own
   localparam int CLEAR_BIT = 7;
   localparam int SERIAL_BIT = 0;

   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(4);

   localparam logic [BANK_W-1:0] PRG_HIGH_BANK = BANK_W'(15);
   localparam logic [BANK_W-1:0] RESET_PRG_LOW = BANK_W'(14);
   localparam logic [BANK_W-1:0] RESET_CHR_LOW = BANK_W'(0);
   localparam logic [BANK_W-1:0] RESET_CHR_HIGH = BANK_W'(1);

   typedef enum logic [1:0] {
      SEL_CONTROL = 2'd0,
      SEL_CHR_ZERO = 2'd1,
      SEL_CHR_ONE = 2'd2,
      SEL_PRG = 2'd3
   } sbsm_sel_type;

   // decoded write as held in the input register
   typedef struct packed {
      sbsm_sel_type sel;
      logic clear;
      logic serial;
   } sbsm_cmd_type;

   typedef struct packed {
      logic [BANK_W-1:0] prg_low_bank;
      logic [BANK_W-1:0] chr_low_bank;
      logic [BANK_W-1:0] chr_high_bank;
      logic [BANK_W-1:0] control_value;
   } sbsm_result_type;

endpackage

// ===== src/sbsm_req_if.sv =====
interface sbsm_req_if;
   import sbsm_pkg::*;

   logic valid;
   logic ready;
   logic [ADDR_W-1:0] address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output address, output write_data, input ready);
   modport sink (input valid, input address, input write_data, output ready);
endinterface

// ===== src/sbsm_rsp_if.sv =====
interface sbsm_rsp_if;
   import sbsm_pkg::*;

   logic valid;
   logic ready;
   logic [BANK_W-1:0] prg_low_bank;
   logic [BANK_W-1:0] prg_high_bank;
   logic [BANK_W-1:0] chr_low_bank;
   logic [BANK_W-1:0] chr_high_bank;
   logic [BANK_W-1:0] control_value;

   modport source (
      output valid, output prg_low_bank, output prg_high_bank,
      output chr_low_bank, output chr_high_bank, output control_value,
      input ready
   );
   modport sink (
      input valid, input prg_low_bank, input prg_high_bank,
      input chr_low_bank, input chr_high_bank, input control_value,
      output ready
   );
endinterface

// ===== src/sbsm_core.sv =====
module sbsm_core (
   input logic clock,
   input logic reset,
   input logic step,
   input sbsm_pkg::sbsm_cmd_type cmd,
   output sbsm_pkg::sbsm_result_type result
);
   import sbsm_pkg::*;

   // shift register never holds a set bit 4 between writes
   logic [BANK_W-2:0] shift_ff, shift_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [BANK_W-1:0] control_ff, control_in;
   logic [BANK_W-1:0] chr_sel0_ff, chr_sel0_in;
   logic [BANK_W-1:0] chr_sel1_ff, chr_sel1_in;
   logic [BANK_W-1:0] prg_sel_ff, prg_sel_in;
   logic [BANK_W-1:0] prg_win_ff, prg_win_in;
   logic [BANK_W-1:0] chr_win_lo_ff, chr_win_lo_in;
   logic [BANK_W-1:0] chr_win_hi_ff, chr_win_hi_in;
   logic [BANK_W-1:0] full;

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      control_in = control_ff;
      chr_sel0_in = chr_sel0_ff;
      chr_sel1_in = chr_sel1_ff;
      prg_sel_in = prg_sel_ff;
      full = {cmd.serial, shift_ff};

      if (cmd.clear) begin
         shift_in = '0;
         count_in = '0;
      end else if (count_ff != LAST_COUNT) begin
         shift_in = {cmd.serial, shift_ff[BANK_W-2:1]};
         count_in = count_ff + COUNT_W'(1);
      end else begin
         case (cmd.sel)
            SEL_CONTROL: control_in = full;
            SEL_CHR_ZERO: chr_sel0_in = full;
            SEL_CHR_ONE: chr_sel1_in = full;
            SEL_PRG: prg_sel_in = full;
            default: control_in = control_ff;
         endcase
         shift_in = '0;
         count_in = '0;
      end

      // windows follow the registers as written by this transaction when the control value selects them
      chr_win_lo_in = control_in[4] ? chr_sel0_in : chr_win_lo_ff;
      chr_win_hi_in = control_in[4] ? chr_sel1_in : chr_win_hi_ff;
      prg_win_in = (control_in[3:2] == 2'b11) ? prg_sel_in : prg_win_ff;

      result.prg_low_bank = prg_win_in;
      result.chr_low_bank = chr_win_lo_in;
      result.chr_high_bank = chr_win_hi_in;
      result.control_value = control_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         count_ff <= '0;
         control_ff <= '0;
         chr_sel0_ff <= '0;
         chr_sel1_ff <= '0;
         prg_sel_ff <= '0;
         prg_win_ff <= RESET_PRG_LOW;
         chr_win_lo_ff <= RESET_CHR_LOW;
         chr_win_hi_ff <= RESET_CHR_HIGH;
      end else if (step) begin
         shift_ff <= shift_in;
         count_ff <= count_in;
         control_ff <= control_in;
         chr_sel0_ff <= chr_sel0_in;
         chr_sel1_ff <= chr_sel1_in;
         prg_sel_ff <= prg_sel_in;
         prg_win_ff <= prg_win_in;
         chr_win_lo_ff <= chr_win_lo_in;
         chr_win_hi_ff <= chr_win_hi_in;
      end
   end

endmodule

// ===== src/serial_bank_switch_mapper.sv =====
// Serial bank-switch mapper register interface.
// req carries one CPU write (address, write_data) per transaction. Data bit 0
// is shifted into a 5-bit loader; the fifth write lands in the register
// picked by address bits 14:13 (control, CHR bank 0, CHR bank 1, PRG bank).
// A write with data bit 7 set clears the loader and its counter.
// rsp returns one transaction per write with the bank numbers of the four
// windows and the control register as they stand after that write.
// rsp valid rises once a write has passed the input register, then the update
// logic into the result register; a stalled result register delays it further.
// Throughput is one write per cycle while rsp is not stalled.
// When rsp is stalled the result register holds, the input register keeps
// taking one more write, and req.ready drops once both are full; no
// transaction is lost or duplicated.
// Synchronous reset empties both stages and restores the power-up banks:
// PRG low 14, PRG high 15, CHR 0 and 1, control 0.
module serial_bank_switch_mapper (
   input logic clock,
   input logic reset,
   sbsm_req_if.sink req,
   sbsm_rsp_if.source rsp
);
   import sbsm_pkg::*;

   logic in_valid_ff, in_valid_in;
   sbsm_cmd_type cmd_ff;
   logic out_valid_ff, out_valid_in;
   sbsm_result_type result_ff;
   sbsm_result_type result;
   logic out_free;
   logic step;
   logic req_take;

   assign out_free = !out_valid_ff || rsp.ready;
   assign step = in_valid_ff && out_free;
   assign req.ready = !in_valid_ff || out_free;
   assign req_take = req.valid && req.ready;

   assign in_valid_in = req_take || (in_valid_ff && !out_free);
   assign out_valid_in = step || (out_valid_ff && !rsp.ready);

   sbsm_core u_core (
      .clock (clock),
      .reset (reset),
      .step (step),
      .cmd (cmd_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff.sel <= sbsm_sel_type'(req.address[SEL_MSB:SEL_LSB]);
         cmd_ff.clear <= req.write_data[CLEAR_BIT];
         cmd_ff.serial <= req.write_data[SERIAL_BIT];
      end
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.prg_low_bank = result_ff.prg_low_bank;
   assign rsp.prg_high_bank = PRG_HIGH_BANK;
   assign rsp.chr_low_bank = result_ff.chr_low_bank;
   assign rsp.chr_high_bank = result_ff.chr_high_bank;
   assign rsp.control_value = result_ff.control_value;

endmodule
